### src/sfr_pkg.sv
package sfr_pkg;

  localparam int SFR_MAX_FIND    = 8;
  localparam int SFR_MAX_REPLACE = 8;
  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 4;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_ADDR_W      = 5;
  localparam int REG_IDX_W       = 2;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_FIND_PATTERN    = 2'd0;
  localparam reg_idx_t REG_FIND_LEN        = 2'd1;
  localparam reg_idx_t REG_REPLACE_PATTERN = 2'd2;
  localparam reg_idx_t REG_REPLACE_LEN     = 2'd3;

  localparam logic [CFG_DATA_W-1:0] FIND_PATTERN_RST    = 64'd60;
  localparam logic [LEN_W-1:0]      FIND_LEN_RST        = 4'd1;
  localparam logic [CFG_DATA_W-1:0] REPLACE_PATTERN_RST = 64'd997485606;
  localparam logic [LEN_W-1:0]      REPLACE_LEN_RST     = 4'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              run_last;
    logic              text_last;
  } sfr_ent_t;

  typedef struct packed {
    logic load;
    logic shift;
  } sfr_win_ctl_t;

  typedef struct packed {
    logic load;
    logic pop;
  } sfr_out_ctl_t;

endpackage

### src/sfr_win_cell.sv
module sfr_win_cell import sfr_pkg::*; (
  input  logic              clk,
  input  sfr_win_ctl_t      ctl,
  input  logic              ins,
  input  logic              cmp_en,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic [BYTE_W-1:0] pat_byte,
  input  logic [BYTE_W-1:0] nb_post,
  output logic [BYTE_W-1:0] post,
  output logic              match
);

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  assign post     = ins ? in_byte : byte_r;
  assign match    = !cmp_en || (post == pat_byte);
  assign byte_nxt = ctl.shift ? nb_post : post;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      byte_r <= byte_nxt;
    end
  end

endmodule

### src/sfr_out_cell.sv
module sfr_out_cell import sfr_pkg::*; (
  input  logic         clk,
  input  sfr_out_ctl_t ctl,
  input  sfr_ent_t     new_ent,
  input  sfr_ent_t     nb_ent,
  output sfr_ent_t     ent
);

  sfr_ent_t ent_r;
  sfr_ent_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.load) begin
      ent_nxt = new_ent;
    end else if (ctl.pop) begin
      ent_nxt = nb_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

### src/stream_find_and_replace.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_text_byte[7:0], in_text_last
// out     | output    | out_valid/out_stall| out_byte[7:0], out_run_last, out_text_last
// cfg     | input     | psel/penable/pready| paddr[4:0], pwrite, pwdata[63:0], prdata[63:0]
//
// An item is taken when in_stall is low; all its results enter the output queue at once.
// Results leave the queue one per cycle while out_stall is low, so an item with k
// results holds input until all but one have left; items with at most one result
// stream at one per cycle. Input stalls while more than one result is queued.
// Reset (rst_n low, synchronous) empties the window and queue and restores registers.
module stream_find_and_replace import sfr_pkg::*; #(
  parameter int MAX_FIND_BYTES    = SFR_MAX_FIND,
  parameter int MAX_REPLACE_BYTES = SFR_MAX_REPLACE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_text_byte,
  input  logic                  in_text_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  out_run_last,
  output logic                  out_text_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int MAX_RES = (MAX_FIND_BYTES > MAX_REPLACE_BYTES) ?
                           MAX_FIND_BYTES : MAX_REPLACE_BYTES;
  localparam int QD  = MAX_RES + 1;
  localparam int FW  = $clog2(MAX_FIND_BYTES + 1);
  localparam int CW  = $clog2(QD + 1);
  localparam int QIW = $clog2(QD);

  logic [CFG_DATA_W-1:0] find_pattern_r;
  logic [LEN_W-1:0]      find_len_r;
  logic [CFG_DATA_W-1:0] replace_pattern_r;
  logic [LEN_W-1:0]      replace_len_r;

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      find_pattern_r    <= FIND_PATTERN_RST;
      find_len_r        <= FIND_LEN_RST;
      replace_pattern_r <= REPLACE_PATTERN_RST;
      replace_len_r     <= REPLACE_LEN_RST;
    end else if (wr) begin
      case (idx)
        REG_FIND_PATTERN:    find_pattern_r    <= pwdata;
        REG_FIND_LEN:        find_len_r        <= pwdata[LEN_W-1:0];
        REG_REPLACE_PATTERN: replace_pattern_r <= pwdata;
        REG_REPLACE_LEN:     replace_len_r     <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FIND_PATTERN:    prdata = find_pattern_r;
      REG_FIND_LEN:        prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, find_len_r};
      REG_REPLACE_PATTERN: prdata = replace_pattern_r;
      REG_REPLACE_LEN:     prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, replace_len_r};
      default:             prdata = '0;
    endcase
  end

  logic [FW-1:0] flen;
  logic [CW-1:0] rlen;
  logic          enabled;

  always_comb begin
    if (find_len_r == '0) begin
      flen = FW'(1);
    end else if (find_len_r > LEN_W'(MAX_FIND_BYTES)) begin
      flen = FW'(MAX_FIND_BYTES);
    end else begin
      flen = find_len_r[FW-1:0];
    end
    if (replace_len_r > LEN_W'(MAX_REPLACE_BYTES)) begin
      rlen = CW'(MAX_REPLACE_BYTES);
    end else begin
      rlen = CW'(replace_len_r);
    end
  end

  assign enabled = (find_len_r != '0) && (replace_len_r != '0);

  logic [FW-1:0]             fill_r;
  logic [FW-1:0]             fill_nxt;
  logic [FW-1:0]             fill_p1;
  logic                      accept;
  logic                      pop_win;
  logic                      hit;
  logic [MAX_FIND_BYTES-1:0] match;
  logic [BYTE_W-1:0]         post [MAX_FIND_BYTES];
  sfr_win_ctl_t              win_ctl;
  logic [CW-1:0]             k;

  assign accept  = in_valid && !in_stall;
  assign fill_p1 = fill_r + FW'(1);
  assign pop_win = fill_p1 >= flen;
  assign hit     = enabled && (fill_p1 == flen) && (&match);

  assign win_ctl.load  = accept;
  assign win_ctl.shift = pop_win && !hit;

  for (genvar i = 0; i < MAX_FIND_BYTES; i++) begin : g_win
    logic [BYTE_W-1:0] nb;
    if (i == MAX_FIND_BYTES - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = post[i+1];
    end
    sfr_win_cell u_cell (
      .clk      (clk),
      .ctl      (win_ctl),
      .ins      (fill_r == FW'(i)),
      .cmp_en   (FW'(i) < flen),
      .in_byte  (in_text_byte),
      .pat_byte (find_pattern_r[BYTE_W*i +: BYTE_W]),
      .nb_post  (nb),
      .post     (post[i]),
      .match    (match[i])
    );
  end

  always_comb begin
    if (hit) begin
      k = rlen;
    end else if (in_text_last) begin
      k = CW'(fill_p1);
    end else if (pop_win) begin
      k = CW'(1);
    end else begin
      k = '0;
    end
    fill_nxt = fill_r;
    if (accept) begin
      if (hit || in_text_last) begin
        fill_nxt = '0;
      end else if (!pop_win) begin
        fill_nxt = fill_p1;
      end
    end
  end

  sfr_ent_t res [QD];

  for (genvar j = 0; j < QD; j++) begin : g_res
    logic [BYTE_W-1:0] rep_b;
    logic [BYTE_W-1:0] win_b;
    if (j < MAX_REPLACE_BYTES) begin : g_rep
      assign rep_b = replace_pattern_r[BYTE_W*j +: BYTE_W];
    end else begin : g_norep
      assign rep_b = '0;
    end
    if (j < MAX_FIND_BYTES) begin : g_wb
      assign win_b = post[j];
    end else begin : g_nowb
      assign win_b = '0;
    end
    assign res[j].data      = hit ? rep_b : win_b;
    assign res[j].run_last  = (CW'(j) == k - CW'(1));
    assign res[j].text_last = (CW'(j) == k - CW'(1)) && in_text_last;
  end

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [CW-1:0] base;
  logic          out_pop;
  sfr_ent_t      ent [QD];

  assign out_valid = cnt_r != '0;
  assign out_pop   = out_valid && !out_stall;
  assign in_stall  = cnt_r > CW'(1);
  assign base      = cnt_r - CW'(out_pop);
  assign cnt_nxt   = base + (accept ? k : CW'(0));

  for (genvar i = 0; i < QD; i++) begin : g_out
    logic [CW-1:0] slot;
    sfr_out_ctl_t  octl;
    sfr_ent_t      nb;
    assign slot      = CW'(i) - base;
    assign octl.load = accept && (CW'(i) >= base) && (slot < k);
    assign octl.pop  = out_pop;
    if (i == QD - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = ent[i+1];
    end
    sfr_out_cell u_cell (
      .clk     (clk),
      .ctl     (octl),
      .new_ent (res[slot[QIW-1:0]]),
      .nb_ent  (nb),
      .ent     (ent[i])
    );
  end

  assign out_byte      = ent[0].data;
  assign out_run_last  = ent[0].run_last;
  assign out_text_last = ent[0].text_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cnt_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

### src/sfr_checker.sv
module sfr_checker import sfr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_byte,
  input logic              out_run_last,
  input logic              out_text_last,
  input logic              pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled output item changed");

  a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_text_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_last |-> out_run_last)
    else $error("text end not on run end");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_run_last |=> out_valid)
    else $error("run broken before its last item");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("config port not ready");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (.*);

### sim/stream_find_and_replace_tb.sv
`timescale 1ns / 100ps

module stream_find_and_replace_tb;
  import sfr_pkg::*;

  localparam int RST_CYCLES   = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 150;
  localparam int RAND_ITEMS   = 150;
  localparam int MAX_CYCLES   = 400000;
  localparam int NUM_ROWS     = 40;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    reg_idx_t              idx;
    logic [CFG_DATA_W-1:0] wval;
    logic [BYTE_W-1:0]     tbyte;
    logic                  tlast;
    logic                  typed;
    logic [LEN_W-1:0]      exp_n;
    logic [CFG_DATA_W-1:0] exp_bytes;
  } dir_row_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_text_byte  = '0;
  logic                  in_text_last  = 1'b0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_run_last;
  logic                  out_text_last;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr         = '0;
  logic [CFG_DATA_W-1:0] pwdata        = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic [CFG_DATA_W-1:0] find_pat_q = FIND_PATTERN_RST;
  logic [LEN_W-1:0]      find_len_q = FIND_LEN_RST;
  logic [CFG_DATA_W-1:0] rep_pat_q  = REPLACE_PATTERN_RST;
  logic [LEN_W-1:0]      rep_len_q  = REPLACE_LEN_RST;
  logic [BYTE_W-1:0]     win_q [SFR_MAX_FIND];
  int                    win_fill   = 0;

  sfr_ent_t rewritten_q [$];
  int       err_cnt       = 0;
  int       send_idle_pct = 0;
  int       stall_pct     = 0;
  int       hold_reqs     = 0;
  int       cycle_cnt     = 0;

  dir_row_t dir_tab [NUM_ROWS] = '{
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h3C, 1'b0, 1'b1, 4'd4, 64'h3B746C26},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h00, 1'b0, 1'b1, 4'd1, 64'h00},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'hFF, 1'b1, 1'b1, 4'd1, 64'hFF},
    '{ROW_CFG, REG_FIND_PATTERN, 64'h636261, 8'h00, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_CFG, REG_FIND_LEN, 64'd3, 8'h00, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_CFG, REG_REPLACE_PATTERN, '1, 8'h00, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_CFG, REG_REPLACE_LEN, 64'd8, 8'h00, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h78, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h61, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h62, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h63, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h79, 1'b1, 1'b0, 4'd0, 64'd0},
    '{ROW_CFG, REG_FIND_LEN, 64'd0, 8'h00, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h5A, 1'b0, 1'b1, 4'd1, 64'h5A},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'hA5, 1'b1, 1'b1, 4'd1, 64'hA5},
    '{ROW_CFG, REG_FIND_PATTERN, 64'h0807060504030201, 8'h00, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_CFG, REG_FIND_LEN, 64'd15, 8'h00, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_CFG, REG_REPLACE_PATTERN, 64'd0, 8'h00, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_CFG, REG_REPLACE_LEN, 64'd15, 8'h00, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h01, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h02, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h03, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h04, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h05, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_CFG, REG_FIND_LEN, 64'd2, 8'h00, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h06, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h07, 1'b1, 1'b0, 4'd0, 64'd0},
    '{ROW_CFG, REG_REPLACE_LEN, 64'd0, 8'h00, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h01, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h02, 1'b1, 1'b0, 4'd0, 64'd0},
    '{ROW_CFG, REG_FIND_LEN, 64'd8, 8'h00, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_CFG, REG_REPLACE_LEN, 64'd15, 8'h00, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h01, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h02, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h03, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h04, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h05, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h06, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h07, 1'b0, 1'b0, 4'd0, 64'd0},
    '{ROW_ITEM, REG_FIND_PATTERN, 64'd0, 8'h08, 1'b1, 1'b0, 4'd0, 64'd0}
  };

  stream_find_and_replace u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == MAX_CYCLES) begin
      $display("stream_find_and_replace_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [BYTE_W-1:0] pop_window();
    logic [BYTE_W-1:0] b;
    int i;
    b = win_q[0];
    for (i = 1; i < SFR_MAX_FIND; i++) win_q[i-1] = win_q[i];
    win_q[SFR_MAX_FIND-1] = '0;
    if (win_fill > 0) win_fill--;
    return b;
  endfunction

  function automatic int rewrite_byte(input logic [BYTE_W-1:0] b, input logic last,
                                      output sfr_ent_t res [SFR_MAX_FIND]);
    int flen, rlen, n, i;
    logic hit;
    flen = int'(find_len_q);
    rlen = int'(rep_len_q);
    hit  = (find_len_q != 0) && (rep_len_q != 0);
    n    = 0;
    if (flen == 0) flen = 1;
    if (flen > SFR_MAX_FIND) flen = SFR_MAX_FIND;
    if (rlen > SFR_MAX_REPLACE) rlen = SFR_MAX_REPLACE;
    if (win_fill >= SFR_MAX_FIND) win_fill = SFR_MAX_FIND - 1;
    win_q[win_fill] = b;
    win_fill++;
    if (win_fill > flen) begin
      res[n] = {pop_window(), 1'b0, 1'b0};
      n++;
    end else if (win_fill == flen) begin
      for (i = 0; i < flen; i++) begin
        if (win_q[i] != find_pat_q[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (i = 0; i < rlen; i++) begin
          res[n] = {rep_pat_q[8*i +: 8], 1'b0, 1'b0};
          n++;
        end
        win_fill = 0;
      end else begin
        res[n] = {pop_window(), 1'b0, 1'b0};
        n++;
      end
    end
    if (last) begin
      while (win_fill > 0) begin
        res[n] = {pop_window(), 1'b0, 1'b0};
        n++;
      end
    end
    if (n > 0) begin
      res[n-1].run_last  = 1'b1;
      res[n-1].text_last = last;
    end
    return n;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    if ($urandom_range(9) == 0) return LEN_W'($urandom_range(15));
    return LEN_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_pattern();
    logic [CFG_DATA_W-1:0] p;
    int i;
    p = {$urandom, $urandom};
    if ($urandom_range(3) == 0) begin
      for (i = 0; i < 8; i++) p[8*i +: 8] = 8'h61 + 8'($urandom_range(2));
    end
    return p;
  endfunction

  task automatic send_text(input logic [BYTE_W-1:0] b, input logic last, input logic typed,
                           input logic [LEN_W-1:0] n_typed,
                           input logic [CFG_DATA_W-1:0] typed_bytes);
    sfr_ent_t res [SFR_MAX_FIND];
    sfr_ent_t ent;
    int n, i;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_text_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = rewrite_byte(b, last, res);
    if (typed) begin
      for (i = 0; i < int'(n_typed); i++) begin
        ent.data      = typed_bytes[8*i +: 8];
        ent.run_last  = (i == int'(n_typed) - 1);
        ent.text_last = ent.run_last & last;
        rewritten_q.push_back(ent);
      end
    end else begin
      for (i = 0; i < n; i++) rewritten_q.push_back(res[i]);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FIND_PATTERN:    find_pat_q = val;
      REG_FIND_LEN:        find_len_q = val[LEN_W-1:0];
      REG_REPLACE_PATTERN: rep_pat_q  = val;
      REG_REPLACE_LEN:     rep_len_q  = val[LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_out();
    sfr_ent_t want;
    if (rewritten_q.size() == 0) begin
      err_cnt++;
      $display("%0t: unexpected item, byte %02h run_last %0b text_last %0b",
               $time, out_byte, out_run_last, out_text_last);
    end else begin
      want = rewritten_q.pop_front();
      if (out_byte !== want.data) begin
        err_cnt++;
        $display("%0t: out_byte expected %02h, got %02h", $time, want.data, out_byte);
      end
      if (out_run_last !== want.run_last) begin
        err_cnt++;
        $display("%0t: out_run_last expected %0b, got %0b",
                 $time, want.run_last, out_run_last);
      end
      if (out_text_last !== want.text_last) begin
        err_cnt++;
        $display("%0t: out_text_last expected %0b, got %0b",
                 $time, want.text_last, out_text_last);
      end
    end
  endtask

  initial begin : rx_side
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_out();
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin : tx_side
    logic [BYTE_W-1:0] txt [$];
    int k, ph, sent, tlen, fl, r, i, pl, mid, quota;
    foreach (win_q[k]) win_q[k] = '0;
    sent = 0;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < NUM_ROWS; k++) begin
      if (dir_tab[k].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tab[k].idx, dir_tab[k].wval);
      end else begin
        send_text(dir_tab[k].tbyte, dir_tab[k].tlast, dir_tab[k].typed,
                  dir_tab[k].exp_n, dir_tab[k].exp_bytes);
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 55; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 55; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      while (sent < (ph + 1) * RAND_ITEMS / 4) begin
        settle();
        write_reg(REG_FIND_PATTERN, pick_pattern());
        write_reg(REG_FIND_LEN, 64'(pick_len()));
        write_reg(REG_REPLACE_PATTERN, pick_pattern());
        write_reg(REG_REPLACE_LEN, 64'(pick_len()));
        fl = (find_len_q == 0) ? 1 : ((find_len_q > SFR_MAX_FIND) ? SFR_MAX_FIND
                                                                    : int'(find_len_q));
        quota = (ph + 1) * RAND_ITEMS / 4 - sent;
        tlen = $urandom_range(1, 24);
        if (tlen > quota) tlen = quota;
        txt.delete();
        while (txt.size() < tlen) begin
          r = $urandom_range(9);
          if (r < 4) begin
            for (i = 0; i < fl; i++) txt.push_back(find_pat_q[8*i +: 8]);
          end else if (r < 6) begin
            pl = $urandom_range(fl - 1);
            for (i = 0; i < pl; i++) txt.push_back(find_pat_q[8*i +: 8]);
            txt.push_back(8'($urandom_range(255)));
          end else if (r < 9) begin
            txt.push_back(8'($urandom_range(255)));
          end else begin
            txt.push_back(find_pat_q[8*$urandom_range(fl - 1) +: 8]);
          end
        end
        while (txt.size() > tlen) void'(txt.pop_back());
        mid = -1;
        if (txt.size() > 1 && $urandom_range(9) == 0) mid = $urandom_range(txt.size() - 2);
        if ((ph == 0 || ph == 2) && sent == ph * RAND_ITEMS / 4) hold_reqs++;
        for (i = 0; i < txt.size(); i++) begin
          send_text(txt[i], i == txt.size() - 1, 1'b0, '0, '0);
          sent++;
          if (i == mid) begin
            settle();
            write_reg(REG_FIND_LEN, 64'($urandom_range(1, 8)));
          end
        end
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("stream_find_and_replace_tb: done, clean");
    end else begin
      $display("stream_find_and_replace_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
src/sfr_pkg.sv
src/sfr_win_cell.sv
src/sfr_out_cell.sv
src/stream_find_and_replace.sv
src/sfr_checker.sv
sim/stream_find_and_replace_tb.sv
